[hw/rtl/doeq_pkg.sv]
// Shared types and constants for the deadline ordered event queue.
package doeq_pkg;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_QUEUED = 2'd2
    } t_status;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic        cmd;
        logic [61:0] deadline;
        logic [6:0]  slot;
    } t_op;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_SCAN,
        BS_INS_RD,
        BS_INS_WAIT,
        BS_INS_CMP,
        BS_REM_RD,
        BS_REM_WAIT,
        BS_REM_CMP,
        BS_LINK,
        BS_HEAD_RD,
        BS_HEAD_WAIT,
        BS_DONE
    } t_bstate;

endpackage

[hw/rtl/doeq_front.sv]
// Front end: accepts items, forms the absolute deadline, queues the op.
module doeq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_cmd,
    input  logic [31:0]       i_stamp_secs,
    input  logic [29:0]       i_stamp_nsecs,
    input  logic [31:0]       i_offset_secs,
    input  logic [29:0]       i_offset_nsecs,
    input  logic [6:0]        i_slot_in,
    output logic              o_op_valid,
    output doeq_pkg::t_op     o_op,
    input  logic              i_op_take
);
    // Two-entry op queue; stage register holds the adder output.
    logic              r_s_valid;
    logic              r_s_cmd;
    logic       [31:0] r_s_secs;
    logic       [30:0] r_s_ns;
    logic        [6:0] r_s_slot;
    doeq_pkg::t_op     r_q [2];
    logic        [1:0] r_cnt;
    logic              r_rd, r_wr;
    logic       [31:0] n_secs;
    logic       [30:0] ns1, ns2;
    logic              c1, c2;
    logic              acc, enq;

    assign acc = i_push && !o_full;
    // stage counts toward the queue, so full reserves space for it
    assign o_full = ({1'b0, r_cnt} + {2'b0, r_s_valid}) >= 3'd2;

    always_comb begin
        c1  = r_s_ns >= {1'b0, doeq_pkg::NS_PER_SEC};
        ns1 = c1 ? r_s_ns - {1'b0, doeq_pkg::NS_PER_SEC} : r_s_ns;
        c2  = ns1 >= {1'b0, doeq_pkg::NS_PER_SEC};
        ns2 = c2 ? ns1 - {1'b0, doeq_pkg::NS_PER_SEC} : ns1;
        n_secs = r_s_secs + {31'd0, c1} + {31'd0, c2};
    end

    assign enq = r_s_valid;
    assign o_op_valid = r_cnt != 2'd0;
    assign o_op = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            r_s_valid <= acc;
            if (enq) r_wr <= ~r_wr;
            if (i_op_take && o_op_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, enq} - {1'b0, i_op_take && o_op_valid};
        end
        if (acc) begin
            r_s_cmd  <= i_cmd;
            r_s_secs <= i_stamp_secs + i_offset_secs;
            r_s_ns   <= {1'b0, i_stamp_nsecs} + {1'b0, i_offset_nsecs};
            r_s_slot <= i_slot_in;
        end
        if (enq) r_q[r_wr] <= '{cmd: r_s_cmd, deadline: {n_secs, ns2[29:0]},
                                slot: r_s_slot};
    end

    ap_nofill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("op queue overrun");
    ap_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_full) else $error("full not raised");
    ap_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s_valid) else $error("stage lost");
endmodule

[hw/rtl/doeq_back.sv]
// Back end: slot allocation and sorted linked-list walk over memories.
module doeq_back #(
    parameter int SLOTS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  doeq_pkg::t_op     i_op,
    output logic              o_op_take,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output logic [1:0]        o_status,
    output logic [6:0]        o_slot_out,
    output logic              o_head_valid,
    output logic [6:0]        o_head_slot,
    output logic [31:0]       o_head_secs,
    output logic [29:0]       o_head_nsecs,
    output logic [7:0]        o_occupancy
);
    localparam int AW = $clog2(SLOTS);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] LEND = LW'(SLOTS);

    logic [61:0]   m_dl   [SLOTS];
    logic [LW-1:0] m_nx   [SLOTS];
    logic [SLOTS-1:0] r_busy;
    logic [LW-1:0] r_head, r_prev, r_cur;
    logic [AW-1:0] r_cursor, r_scan, r_slot;
    logic [LW-1:0] r_cnt_scan;
    logic [LW-1:0] r_count;
    doeq_pkg::t_op r_op;
    doeq_pkg::t_bstate r_st, n_st;
    logic [61:0]   r_rd_dl;
    logic [LW-1:0] r_rd_nx;
    logic [AW-1:0] r_rd_addr;
    logic          r_res_valid;
    logic [1:0]    r_status;
    logic [6:0]    r_slot_out;
    logic          r_hv;
    logic [6:0]    r_hs;
    logic [61:0]   r_hd;
    logic [7:0]    r_occ;
    logic          ins_le, cur_end, tgt_ok;
    logic [LW-1:0] tgt;

    assign cur_end = r_cur >= LEND;
    assign ins_le  = r_op.deadline <= r_rd_dl;
    assign tgt     = LW'(r_op.slot);
    assign tgt_ok  = tgt < LEND && r_busy[tgt[AW-1:0]];

    // Memory read port: address chosen from the state, read data registered for the next cycle.
    always_ff @(posedge i_clk) begin
        r_rd_dl <= m_dl[r_rd_addr];
        r_rd_nx <= m_nx[r_rd_addr];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            doeq_pkg::BS_IDLE:
                if (i_op_valid && !r_res_valid)
                    n_st = (i_op.cmd == doeq_pkg::CMD_INSERT) ? doeq_pkg::BS_SCAN
                                                               : doeq_pkg::BS_REM_RD;
            doeq_pkg::BS_SCAN:
                if (r_op.cmd == doeq_pkg::CMD_REMOVE) n_st = doeq_pkg::BS_DONE;
                else if (!r_busy[r_scan]) n_st = doeq_pkg::BS_INS_RD;
                else if (r_cnt_scan == LEND - LW'(1)) n_st = doeq_pkg::BS_DONE;
            doeq_pkg::BS_INS_RD:
                n_st = cur_end ? doeq_pkg::BS_LINK : doeq_pkg::BS_INS_WAIT;
            doeq_pkg::BS_INS_WAIT: n_st = doeq_pkg::BS_INS_CMP;
            doeq_pkg::BS_INS_CMP:
                n_st = ins_le ? doeq_pkg::BS_LINK : doeq_pkg::BS_INS_RD;
            doeq_pkg::BS_REM_RD:
                if (!tgt_ok) n_st = doeq_pkg::BS_DONE;
                else n_st = doeq_pkg::BS_REM_WAIT;
            doeq_pkg::BS_REM_WAIT: n_st = doeq_pkg::BS_REM_CMP;
            doeq_pkg::BS_REM_CMP:
                n_st = (r_cur == tgt) ? doeq_pkg::BS_LINK : doeq_pkg::BS_REM_WAIT;
            doeq_pkg::BS_LINK: n_st = doeq_pkg::BS_HEAD_RD;
            doeq_pkg::BS_HEAD_RD: n_st = doeq_pkg::BS_HEAD_WAIT;
            doeq_pkg::BS_HEAD_WAIT: n_st = doeq_pkg::BS_DONE;
            doeq_pkg::BS_DONE: n_st = doeq_pkg::BS_IDLE;
            default: n_st = doeq_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_op_take = (r_st == doeq_pkg::BS_IDLE) && i_op_valid && !r_res_valid;
        unique case (r_st)
            doeq_pkg::BS_REM_RD, doeq_pkg::BS_REM_WAIT: r_rd_addr = r_cur[AW-1:0];
            // head deadline must still be on the read data in DONE
            doeq_pkg::BS_HEAD_RD, doeq_pkg::BS_HEAD_WAIT: r_rd_addr = r_head[AW-1:0];
            default: r_rd_addr = r_cur[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= doeq_pkg::BS_IDLE;
            r_busy <= '0;
            r_head <= LEND;
            r_cursor <= '0;
            r_count <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_res_valid && i_res_take) r_res_valid <= 1'b0;
            unique case (r_st)
                doeq_pkg::BS_IDLE:
                    if (o_op_take) begin
                        r_op <= i_op;
                        r_scan <= r_cursor;
                        r_cnt_scan <= '0;
                        r_cur <= r_head;
                        r_prev <= LEND;
                    end
                doeq_pkg::BS_SCAN:
                    if (!r_busy[r_scan]) begin
                        r_slot <= r_scan;
                        r_cursor <= r_scan;
                        r_status <= doeq_pkg::ST_OK;
                        r_slot_out <= 7'(r_scan);
                    end else begin
                        r_scan <= (r_scan == AW'(SLOTS - 1)) ? '0 : r_scan + AW'(1);
                        r_cnt_scan <= r_cnt_scan + LW'(1);
                        r_status <= doeq_pkg::ST_FULL;
                        r_slot_out <= '0;
                    end
                doeq_pkg::BS_INS_CMP:
                    if (!ins_le) begin
                        r_prev <= r_cur;
                        r_cur <= r_rd_nx;
                    end
                doeq_pkg::BS_REM_RD: begin
                    r_slot_out <= r_op.slot;
                    r_status <= tgt_ok ? doeq_pkg::ST_OK : doeq_pkg::ST_NOT_QUEUED;
                end
                doeq_pkg::BS_REM_CMP:
                    if (r_cur != tgt) begin
                        r_prev <= r_cur;
                        r_cur <= r_rd_nx;
                    end
                doeq_pkg::BS_LINK:
                    if (r_op.cmd == doeq_pkg::CMD_INSERT) begin
                        r_busy[r_slot] <= 1'b1;
                        r_count <= r_count + LW'(1);
                        if (r_prev >= LEND) r_head <= LW'(r_slot);
                    end else begin
                        r_busy[tgt[AW-1:0]] <= 1'b0;
                        r_count <= r_count - LW'(1);
                        if (r_prev >= LEND) r_head <= r_rd_nx;
                    end
                doeq_pkg::BS_DONE: r_res_valid <= 1'b1;
                default: ;
            endcase
            if (r_st == doeq_pkg::BS_DONE) begin
                r_hv <= r_head < LEND;
                r_hs <= (r_head < LEND) ? 7'(r_head) : 7'd0;
                r_hd <= (r_head < LEND) ? r_rd_dl : 62'd0;
                r_occ <= 8'(r_count);
            end
        end
    end

    // Memory writes; an insert writes its own entry in LINK and links its predecessor in HEAD_RD
    always_ff @(posedge i_clk) begin
        if (r_st == doeq_pkg::BS_LINK) begin
            if (r_op.cmd == doeq_pkg::CMD_INSERT) begin
                m_dl[r_slot] <= r_op.deadline;
                m_nx[r_slot] <= r_cur;
            end else if (r_prev < LEND) begin
                m_nx[r_prev[AW-1:0]] <= r_rd_nx;
            end
        end else if (r_st == doeq_pkg::BS_HEAD_RD) begin
            if (r_op.cmd == doeq_pkg::CMD_INSERT && r_prev < LEND)
                m_nx[r_prev[AW-1:0]] <= LW'(r_slot);
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_head_valid = r_hv;
    assign o_head_slot  = r_hs;
    assign o_head_secs  = r_hd[61:30];
    assign o_head_nsecs = r_hd[29:0];
    assign o_occupancy  = r_occ;

    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEND) else $error("count above slots");
    ap_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head >= LEND)) else $error("head and count disagree");
    ap_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_take |=> r_st != doeq_pkg::BS_IDLE) else $error("op dropped");
endmodule

[hw/rtl/deadline_ordered_event_queue.sv]
// Top level of the deadline ordered event queue.
//
// Input channel: queue style. Drive push with the item fields; the item
// is taken at a clock edge with push high and full low. cmd 0 inserts an
// event (timestamp plus offset forms its deadline), cmd 1 removes slot_in.
// Result channel: queue style. While empty is low the result is on the
// o_ ports; it is taken at an edge with pop high.
// The front end adds the deadline in one stage and buffers two ops, so it
// keeps accepting while the back end works. The back end walks the slot
// bitmap (one slot per cycle) and then the sorted list (read, wait and
// compare per entry on insert, wait and compare on remove, one memory read
// port); it takes the next op only when idle with no result held.
// Reset (synchronous, i_rst_n low) empties the queue and the buffers; no
// clearing pass is needed since slot memories are only read once written.
// A stalled receiver holds one result; the back end then waits and the front
// end fills and raises full.
module deadline_ordered_event_queue #(
    parameter int SLOTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_stamp_secs,
    input  logic [29:0] i_stamp_nsecs,
    input  logic [31:0] i_offset_secs,
    input  logic [29:0] i_offset_nsecs,
    input  logic [6:0]  i_slot_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [6:0]  o_slot_out,
    output logic        o_head_valid,
    output logic [6:0]  o_head_slot,
    output logic [31:0] o_head_secs,
    output logic [29:0] o_head_nsecs,
    output logic [7:0]  o_occupancy
);
    logic          op_valid, op_take, res_valid;
    doeq_pkg::t_op op;

    doeq_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_cmd,
        .i_stamp_secs, .i_stamp_nsecs, .i_offset_secs, .i_offset_nsecs,
        .i_slot_in, .o_op_valid(op_valid), .o_op(op), .i_op_take(op_take)
    );

    doeq_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_op_valid(op_valid), .i_op(op), .o_op_take(op_take),
        .o_res_valid(res_valid), .i_res_take(pop), .o_status, .o_slot_out,
        .o_head_valid, .o_head_slot, .o_head_secs, .o_head_nsecs, .o_occupancy
    );

    assign empty = !res_valid;
endmodule

[bench/deadline_ordered_event_queue_test.sv]
// Self-checking bench for the deadline ordered event queue.
`timescale 1ns / 100ps

module deadline_ordered_event_queue_test;

    localparam int NSLOT = 128;
    localparam int STALL_LIMIT = 6000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 900;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 450;   // about one worst-case list walk

    // One result item as the block reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  slot;
        logic        head_valid;
        logic [6:0]  head_slot;
        logic [31:0] head_secs;
        logic [29:0] head_nsecs;
        logic [7:0]  occupancy;
    } t_report;

    // Mirror of the queue: predicts the report for every accepted item.
    class edf_scoreboard;
        logic [61:0] deadline [NSLOT];
        int          succ [NSLOT];
        bit          taken [NSLOT];
        int          first;
        int          cursor;
        int          count;
        t_report     pending [$];
        int          errors;

        function new();
            first = NSLOT;
            cursor = 0;
            count = 0;
            errors = 0;
            for (int i = 0; i < NSLOT; i++) begin
                taken[i] = 0;
                succ[i] = 0;
                deadline[i] = '0;
            end
        endfunction

        // Absolute deadline: seconds wrap, nanoseconds carry up to twice.
        function logic [61:0] add_deadline(logic [31:0] s1, logic [29:0] n1,
                                           logic [31:0] s2, logic [29:0] n2);
            logic [31:0] secs;
            logic [30:0] ns;
            secs = s1 + s2;
            ns = {1'b0, n1} + {1'b0, n2};
            repeat (2) begin
                if (ns >= 31'd1000000000) begin
                    ns = ns - 31'd1000000000;
                    secs = secs + 32'd1;
                end
            end
            return {secs, ns[29:0]};
        endfunction

        function t_report report(doeq_pkg::t_status st, int slot);
            t_report r;
            r.status = st;
            r.slot = slot[6:0];
            r.head_valid = first < NSLOT;
            r.head_slot = (first < NSLOT) ? first[6:0] : '0;
            r.head_secs = (first < NSLOT) ? deadline[first][61:30] : '0;
            r.head_nsecs = (first < NSLOT) ? deadline[first][29:0] : '0;
            r.occupancy = count[7:0];
            return r;
        endfunction

        function int any_taken_slot();
            int picks [$];
            for (int i = 0; i < NSLOT; i++)
                if (taken[i]) picks.push_back(i);
            if (picks.size() == 0) return $urandom_range(0, NSLOT - 1);
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction

        function void note_item(logic cmd, logic [31:0] ss, logic [29:0] sn,
                                logic [31:0] os, logic [29:0] on, logic [6:0] target);
            int slot, prev, cur;
            logic [61:0] dl;
            slot = NSLOT;
            prev = NSLOT;
            if (cmd == doeq_pkg::CMD_INSERT) begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!taken[(cursor + i) % NSLOT]) begin
                        slot = (cursor + i) % NSLOT;
                        break;
                    end
                end
                if (slot == NSLOT) begin
                    pending.push_back(report(doeq_pkg::ST_FULL, 0));
                    return;
                end
                cursor = slot;
                taken[slot] = 1;
                dl = add_deadline(ss, sn, os, on);
                deadline[slot] = dl;
                // ties: the newcomer goes ahead of equal deadlines
                cur = first;
                while (cur < NSLOT && dl > deadline[cur]) begin
                    prev = cur;
                    cur = succ[cur];
                end
                succ[slot] = cur;
                if (prev == NSLOT) first = slot;
                else succ[prev] = slot;
                count++;
                pending.push_back(report(doeq_pkg::ST_OK, slot));
            end else begin
                if (!taken[target]) begin
                    pending.push_back(report(doeq_pkg::ST_NOT_QUEUED, target));
                    return;
                end
                cur = first;
                while (cur < NSLOT && cur != target) begin
                    prev = cur;
                    cur = succ[cur];
                end
                if (prev == NSLOT) first = succ[cur];
                else succ[prev] = succ[cur];
                taken[target] = 0;
                count--;
                pending.push_back(report(doeq_pkg::ST_OK, target));
            end
        endfunction

        function void check_item(t_report got);
            t_report exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result, status %0d slot %0d",
                                           got.status, got.slot);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp st %0d sl %0d hv %0b hs %0d %0d.%0d occ %0d / got st %0d sl %0d hv %0b hs %0d %0d.%0d occ %0d",
                             exp.status, exp.slot, exp.head_valid, exp.head_slot,
                             exp.head_secs, exp.head_nsecs, exp.occupancy,
                             got.status, got.slot, got.head_valid, got.head_slot,
                             got.head_secs, got.head_nsecs, got.occupancy);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_cmd;
    logic [31:0] i_stamp_secs;
    logic [29:0] i_stamp_nsecs;
    logic [31:0] i_offset_secs;
    logic [29:0] i_offset_nsecs;
    logic [6:0]  i_slot_in;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic [6:0]  o_slot_out;
    logic        o_head_valid;
    logic [6:0]  o_head_slot;
    logic [31:0] o_head_secs;
    logic [29:0] o_head_nsecs;
    logic [7:0]  o_occupancy;

    deadline_ordered_event_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_stamp_secs  (i_stamp_secs),
        .i_stamp_nsecs (i_stamp_nsecs),
        .i_offset_secs (i_offset_secs),
        .i_offset_nsecs(i_offset_nsecs),
        .i_slot_in     (i_slot_in),
        .empty         (empty),
        .pop           (pop),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_head_valid  (o_head_valid),
        .o_head_slot   (o_head_slot),
        .o_head_secs   (o_head_secs),
        .o_head_nsecs  (o_head_nsecs),
        .o_occupancy   (o_occupancy)
    );

    edf_scoreboard book = new();

    int send_idle_pct = 10;     // percent of cycles the sender sits out
    int recv_idle_pct = 64;     // percent of cycles the receiver sits out
    bit hold_request = 0;       // asks the receiver for one long hold-off
    int quiet_cycles = 0;       // cycles since the last handshake on either side

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: checks accepted results, then decides whether to pop next cycle.
    // A requested hold-off is counted here so the sender keeps pushing meanwhile.
    initial begin
        int hold_left;
        t_report got;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.status = o_status;
                got.slot = o_slot_out;
                got.head_valid = o_head_valid;
                got.head_slot = o_head_slot;
                got.head_secs = o_head_secs;
                got.head_nsecs = o_head_nsecs;
                got.occupancy = o_occupancy;
                book.check_item(got);
            end
            if (hold_request && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any accepted item on either side resets the count.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item and hold it until taken; push stays high into the next item
    // when no idle gap follows, so it gets a single assignment per edge.
    task automatic send_item(logic cmd, logic [31:0] ss, logic [29:0] sn,
                             logic [31:0] os, logic [29:0] on, logic [6:0] target);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= cmd;
        i_stamp_secs <= ss;
        i_stamp_nsecs <= sn;
        i_offset_secs <= os;
        i_offset_nsecs <= on;
        i_slot_in <= target;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        book.note_item(cmd, ss, sn, os, on, target);
    endtask

    task automatic send_insert(logic [31:0] ss, logic [29:0] sn,
                               logic [31:0] os, logic [29:0] on);
        send_item(doeq_pkg::CMD_INSERT, ss, sn, os, on, 7'($urandom));
    endtask

    task automatic send_remove(logic [6:0] target);
        send_item(doeq_pkg::CMD_REMOVE, $urandom, 30'($urandom), $urandom,
                  30'($urandom), target);
    endtask

    // Random insert: small seconds give deep lists and equal-deadline ties.
    task automatic random_insert();
        logic [31:0] ss, os;
        logic [29:0] sn, on;
        case ($urandom_range(0, 9))
            0: begin
                ss = $urandom; os = $urandom;
                sn = 30'($urandom); on = 30'($urandom);   // any 30-bit value
            end
            1, 2: begin
                ss = $urandom_range(0, 3); os = '0;
                sn = '0; on = '0;
            end
            default: begin
                ss = $urandom_range(0, 40); os = $urandom_range(0, 5);
                sn = 30'($urandom_range(0, 999999999));
                on = 30'($urandom_range(0, 999999999));
            end
        endcase
        send_insert(ss, sn, os, on);
    endtask

    task automatic random_item();
        int ins_pct;
        ins_pct = (book.count < 10) ? 75 : 50;
        if ($urandom_range(0, 99) < ins_pct) random_insert();
        else if ($urandom_range(0, 99) < 85) send_remove(7'(book.any_taken_slot()));
        else send_remove(7'($urandom));
    endtask

    initial begin
        push = 1'b0;
        i_cmd = doeq_pkg::CMD_INSERT;
        i_stamp_secs = '0;
        i_stamp_nsecs = '0;
        i_offset_secs = '0;
        i_offset_nsecs = '0;
        i_slot_in = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue remove, wrap, carries, ties, head/middle removal.
        send_remove(7'd5);
        send_insert(32'hFFFF_FFFF, 30'd999999999, 32'hFFFF_FFFF, 30'd999999999);
        send_insert(32'd0, 30'd0, 32'd0, 30'd0);
        send_insert(32'd0, 30'd0, 32'd0, 30'd0);      // ties go ahead of slot 1
        send_insert(32'd0, 30'h3FFF_FFFF, 32'd0, 30'h3FFF_FFFF); // double carry
        send_insert(32'd100, 30'd500000000, 32'd0, 30'd500000000); // exactly one second
        send_insert(32'd5, 30'd999999999, 32'd0, 30'd0);
        send_insert(32'hFFFF_FFFF, 30'd0, 32'd0, 30'd0);
        send_remove(7'd127);
        send_remove(7'd1);                            // middle of a tie
        send_remove(7'd2);                            // current head
        send_remove(7'd2);                            // already freed
        send_insert(32'd0, 30'd0, 32'd0, 30'd1);
        send_remove(7'd0);                            // latest deadline, tail
        send_insert(32'd7, 30'd1, 32'd7, 30'd1);
        send_remove(7'd4);
        send_remove(7'd3);
        send_remove(7'd5);
        send_remove(7'd6);
        send_remove(7'd1);
        send_remove(7'd2);                            // slots 7 and 8 stay queued

        // Random, phase one: sender idles little, receiver a lot.
        repeat (70) random_item();

        // Phase two: roles swapped; fill to capacity and try a few more inserts.
        send_idle_pct = 64;
        recv_idle_pct = 10;
        while (book.count < NSLOT) random_insert();
        repeat (3) random_insert();
        repeat (60) send_remove(7'(book.any_taken_slot()));
        repeat (40) random_item();

        // Phase three: no idling; a long receiver hold-off backs the block up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        repeat (100) random_item();

        push <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
